// File: rtl/heightmap_box_smoother_unit_macros.svh
// Assertion macros shared by the box smoother modules.
`ifndef HEIGHTMAP_BOX_SMOOTHER_UNIT_MACROS_SVH
`define HEIGHTMAP_BOX_SMOOTHER_UNIT_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define HBS_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define HBS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/hbs_pkg.sv
// Shared types, constants and helper functions of the box smoother.
`timescale 1ns / 1ps

package hbs_pkg;

   localparam int MAX_WIDTH   = 1024;
   localparam int MAX_DEPTH   = 1024;
   localparam int POS_W       = 10;
   localparam int DIM_W       = 11;
   localparam int CNT_W       = 11;
   localparam int BYTE_W      = 8;
   localparam int HEIGHT_W    = 16;
   localparam int SUM_W       = 20;
   localparam int CSR_ADDR_W  = 4;
   localparam int CSR_DATA_W  = 32;
   localparam int REQ_TDATA_W = 8;
   localparam int RSP_TDATA_W = 40;
   localparam int RSP_PAD_W   = RSP_TDATA_W - HEIGHT_W - 2 * POS_W;

   localparam logic [DIM_W-1:0] MIN_DIM         = 11'd2;
   localparam logic [DIM_W-1:0] GRID_WIDTH_RST  = 11'd256;
   localparam logic [DIM_W-1:0] GRID_DEPTH_RST  = 11'd256;
   localparam logic             USE_HEIGHTS_RST = 1'b1;

   // floor(x/9) == (x * DIV9_MUL) >> DIV9_SHIFT for every x below 2**20
   localparam logic [SUM_W-1:0] DIV9_MUL   = 20'd932068;
   localparam int               DIV9_SHIFT = 23;
   localparam logic [SUM_W-1:0] ROUND_BIAS = 20'd4;

   typedef enum logic [1:0] {
      REG_GRID_WIDTH    = 2'd0,
      REG_GRID_DEPTH    = 2'd1,
      REG_USE_HEIGHTMAP = 2'd2
   } csr_reg_type;

   typedef struct packed {
      logic [POS_W-1:0] row;
      logic [POS_W-1:0] col;
   } hbs_pos_type;

   // What one accepted item asks of the window stage.
   typedef struct packed {
      logic              sample;    // 1: height sample, 0: drain
      logic              emit;
      logic              interior;
      logic              last;
      logic [POS_W-1:0]  row;
      logic [POS_W-1:0]  col;
      logic [BYTE_W-1:0] raw_byte;
   } hbs_step_type;

   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                  input logic [DIM_W-1:0] hi);
      logic [DIM_W-1:0] r;
      r = v;
      if (v < MIN_DIM) r = MIN_DIM;
      else if (v > hi) r = hi;
      return r;
   endfunction

   function automatic hbs_pos_type advance_pos(input hbs_pos_type p,
                                               input logic [DIM_W-1:0] w,
                                               input logic [DIM_W-1:0] d);
      logic [DIM_W-1:0] c_nxt;
      logic [DIM_W-1:0] r_nxt;
      hbs_pos_type      q;
      c_nxt = DIM_W'(p.col) + DIM_W'(1);
      r_nxt = DIM_W'(p.row);
      if (c_nxt >= w) begin
         c_nxt = '0;
         r_nxt = r_nxt + DIM_W'(1);
      end
      if (r_nxt >= d) r_nxt = '0;
      q.row = r_nxt[POS_W-1:0];
      q.col = c_nxt[POS_W-1:0];
      return q;
   endfunction

   function automatic logic [POS_W-1:0] next_col(input logic [POS_W-1:0] c,
                                                 input logic [DIM_W-1:0] w);
      logic [DIM_W-1:0] c_nxt;
      c_nxt = DIM_W'(c) + DIM_W'(1);
      if (c_nxt >= w) c_nxt = '0;
      return c_nxt[POS_W-1:0];
   endfunction

   function automatic logic [HEIGHT_W-1:0] to_q88(input logic [BYTE_W-1:0] b);
      return {b, 8'h00};
   endfunction

endpackage

// File: rtl/hbs_ram.sv
// Simple dual-port RAM: one write port, one registered read port.
`timescale 1ns / 1ps

module hbs_ram #(
   parameter int  DATA_W = 8,
   parameter int  DEPTH  = 1024,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [DATA_W-1:0] wdata,
   input  logic              re,
   input  logic [ADDR_W-1:0] raddr,
   output logic [DATA_W-1:0] rdata
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rdata_ff;

   // read returns the old word when the same address is written
   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      if (re) rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// File: rtl/hbs_ctrl.sv
// Raster position tracking and per-item decisions of the box smoother.
`timescale 1ns / 1ps
`include "heightmap_box_smoother_unit_macros.svh"

module hbs_ctrl import hbs_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  logic               op,
   input  logic [BYTE_W-1:0]  sample,
   input  logic [DIM_W-1:0]   width,
   input  logic [DIM_W-1:0]   depth,
   output logic               step_active,
   output hbs_step_type       step,
   output logic               raw_we,
   output logic [POS_W-1:0]   raw_waddr,
   output logic [POS_W-1:0]   raw_raddr,
   output logic [POS_W-1:0]   f_raddr
);

   hbs_pos_type      in_pos_ff,  in_pos_in;
   hbs_pos_type      out_pos_ff, out_pos_in;
   logic [CNT_W-1:0] pending_ff, pending_in;

   logic             full;
   logic             emit;
   logic             inner;
   logic             last;
   logic [DIM_W:0]   thresh;
   logic [DIM_W-1:0] orow;
   logic [DIM_W-1:0] ocol;

   always_comb begin
      orow   = DIM_W'(out_pos_ff.row);
      ocol   = DIM_W'(out_pos_ff.col);
      thresh = {1'b0, width} + (DIM_W + 1)'(1);
      // input wrapped to the origin with points still owed: grid complete
      full   = (in_pos_ff.row == '0) && (in_pos_ff.col == '0) && (pending_ff != '0);
      step_active = op ? full : !full;
      emit   = op ? full : (!full && ({1'b0, pending_ff} >= thresh));
      inner  = (orow != '0) && (orow + DIM_W'(1) < depth) &&
               (ocol != '0) && (ocol + DIM_W'(1) < width);
      last   = (orow == depth - DIM_W'(1)) && (ocol == width - DIM_W'(1));
   end

   always_comb begin
      step.sample   = !op;
      step.emit     = emit;
      step.interior = !op && emit && inner;
      step.last     = last;
      step.row      = out_pos_ff.row;
      step.col      = out_pos_ff.col;
      step.raw_byte = sample;
      raw_we        = accept && step_active && !op;
      raw_waddr     = in_pos_ff.col;
      // drains fetch the raw point right of the one being flushed
      raw_raddr     = op ? next_col(out_pos_ff.col, width) : in_pos_ff.col;
      f_raddr       = next_col(out_pos_ff.col, width);
   end

   always_comb begin
      in_pos_in  = in_pos_ff;
      out_pos_in = out_pos_ff;
      pending_in = pending_ff;
      if (accept && step_active) begin
         if (emit) out_pos_in = advance_pos(out_pos_ff, width, depth);
         if (op) begin
            pending_in = pending_ff - CNT_W'(1);
         end else begin
            if (!emit) pending_in = pending_ff + CNT_W'(1);
            in_pos_in = advance_pos(in_pos_ff, width, depth);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_pos_ff  <= '0;
         out_pos_ff <= '0;
         pending_ff <= '0;
      end else begin
         in_pos_ff  <= in_pos_in;
         out_pos_ff <= out_pos_in;
         pending_ff <= pending_in;
      end
   end

   `HBS_ASSERT_NEXT(a_full_sample_ignored, clock, reset, accept && !op && full, $stable(in_pos_ff) && $stable(pending_ff), "sample after a complete grid moved the input position")
   `HBS_ASSERT_NEXT(a_empty_drain_ignored, clock, reset, accept && op && (pending_ff == '0), (pending_ff == '0) && $stable(out_pos_ff), "drain with nothing owed changed state")

endmodule

// File: rtl/hbs_window.sv
// 3x3 window registers, mean calculation and result register.
`timescale 1ns / 1ps
`include "heightmap_box_smoother_unit_macros.svh"

module hbs_window import hbs_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                step_load,
   input  hbs_step_type        step_in,
   input  logic [BYTE_W-1:0]   raw_rd,
   input  logic [HEIGHT_W-1:0] f_rd,
   input  logic                use_heightmap,
   input  logic                rsp_ready,
   output logic                step_ready,
   output logic                f_we,
   output logic [POS_W-1:0]    f_waddr,
   output logic [HEIGHT_W-1:0] f_wdata,
   output logic                rsp_valid,
   output logic [HEIGHT_W-1:0] rsp_height,
   output logic [POS_W-1:0]    rsp_row,
   output logic [POS_W-1:0]    rsp_col,
   output logic                rsp_last
);

   hbs_step_type        s1_ff;
   logic                s1_valid_ff, s1_valid_in;
   logic                s1_go;

   logic                out_valid_ff, out_valid_in;
   logic [HEIGHT_W-1:0] out_height_ff;
   logic [POS_W-1:0]    out_row_ff;
   logic [POS_W-1:0]    out_col_ff;
   logic                out_last_ff;

   // raw bytes: centre point and the two previous samples (bottom row)
   logic [BYTE_W-1:0]   centre_ff;
   logic [BYTE_W-1:0]   bot_c_ff;
   logic [BYTE_W-1:0]   bot_l_ff;
   // finished values: row above and the point to the left
   logic [HEIGHT_W-1:0] top_c_ff;
   logic [HEIGHT_W-1:0] top_l_ff;
   logic [HEIGHT_W-1:0] left_ff;

   logic [SUM_W-1:0]    sum;
   logic [2*SUM_W-1:0]  prod;
   logic [HEIGHT_W-1:0] mean;
   logic [HEIGHT_W-1:0] value;

   always_comb begin
      s1_go      = s1_valid_ff && (!s1_ff.emit || !out_valid_ff || rsp_ready);
      step_ready = !s1_valid_ff || s1_go;

      s1_valid_in = s1_valid_ff;
      if (step_load) s1_valid_in = 1'b1;
      else if (s1_go) s1_valid_in = 1'b0;

      out_valid_in = out_valid_ff;
      if (s1_go && s1_ff.emit) out_valid_in = 1'b1;
      else if (rsp_ready) out_valid_in = 1'b0;
   end

   always_comb begin
      sum = SUM_W'(top_l_ff) + SUM_W'(top_c_ff) + SUM_W'(f_rd) +
            SUM_W'(left_ff) + SUM_W'(to_q88(centre_ff)) + SUM_W'(to_q88(raw_rd)) +
            SUM_W'(to_q88(bot_l_ff)) + SUM_W'(to_q88(bot_c_ff)) +
            SUM_W'(to_q88(s1_ff.raw_byte)) + ROUND_BIAS;
      prod  = (2 * SUM_W)'(sum) * (2 * SUM_W)'(DIV9_MUL);
      mean  = prod[DIV9_SHIFT +: HEIGHT_W];
      value = s1_ff.interior ? mean : to_q88(centre_ff);
   end

   assign f_we    = s1_go && s1_ff.emit;
   assign f_waddr = s1_ff.col;
   assign f_wdata = value;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step_load) s1_ff <= step_in;
      if (s1_go) begin
         centre_ff <= raw_rd;
         if (s1_ff.sample) begin
            bot_l_ff <= bot_c_ff;
            bot_c_ff <= s1_ff.raw_byte;
         end
         if (s1_ff.emit) begin
            top_l_ff      <= top_c_ff;
            top_c_ff      <= f_rd;
            left_ff       <= value;
            out_height_ff <= use_heightmap ? value : '0;
            out_row_ff    <= s1_ff.row;
            out_col_ff    <= s1_ff.col;
            out_last_ff   <= s1_ff.last;
         end
      end
   end

   assign rsp_valid  = out_valid_ff;
   assign rsp_height = out_height_ff;
   assign rsp_row    = out_row_ff;
   assign rsp_col    = out_col_ff;
   assign rsp_last   = out_last_ff;

   `HBS_ASSERT_SAME(a_stall_holds_input, clock, reset, s1_valid_ff && s1_ff.emit && out_valid_ff && !rsp_ready, !step_ready, "window stage took an item while its result was blocked")
   `HBS_ASSERT_NEXT(a_emit_fills_result, clock, reset, s1_go && s1_ff.emit, out_valid_ff, "emitting item left no result")
   `HBS_ASSERT_SAME(a_interior_is_emit, clock, reset, s1_valid_ff && s1_ff.interior, s1_ff.emit && s1_ff.sample, "interior flag on an item that emits nothing")

endmodule

// File: rtl/heightmap_box_smoother_unit.sv
// Heightmap 3x3 box smoother, top level.
//
// req_* carries one item per handshake: a raw height byte (req_tuser low) or a
// drain item (req_tuser high). Bytes arrive in raster order over the grid set by
// the csr_* registers (width, depth, heights on/off). rsp_* returns one smoothed
// Q8.8 point with its row and column; rsp_tlast marks the final point of a grid.
// A point comes out when the sample width+1 places after it is taken; once a
// grid is complete, width+1 drain items flush the remaining points.
// Throughput is one item per cycle while rsp_tready keeps the result moving. An
// accepted item that releases a result passes through one register stage, which holds
// the item and the line memories' read data; the mean is formed and caught in the result register.
// The rate is set by the two line memories (raw bytes and finished values, one
// read and one write port each, a row deep).
// Reset (synchronous) clears positions and the owed-point count and restores the
// register defaults; the line memories are not cleared and need none.
// If rsp_tready stays low the result is held and req_tready drops as soon as
// the next emitting item is waiting behind it.
`timescale 1ns / 1ps

module heightmap_box_smoother_unit import hbs_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,   // [7:0] height_sample
   input  logic                   req_tuser,   // [0] op
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,   // [15:0] height, [25:16] row, [35:26] col
   output logic                   rsp_tlast,
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [CSR_DATA_W-1:0]  csr_pwdata,
   output logic [CSR_DATA_W-1:0]  csr_prdata,
   output logic                   csr_pready
);

   logic [DIM_W-1:0]    grid_width_ff, grid_width_in;
   logic [DIM_W-1:0]    grid_depth_ff, grid_depth_in;
   logic                use_heights_ff, use_heights_in;
   logic                csr_wr;
   csr_reg_type         csr_idx;

   logic [DIM_W-1:0]    width_eff;
   logic [DIM_W-1:0]    depth_eff;

   logic                req_accept;
   logic                step_active;
   hbs_step_type        step;
   logic                step_ready;
   logic                raw_we;
   logic [POS_W-1:0]    raw_waddr;
   logic [POS_W-1:0]    raw_raddr;
   logic [POS_W-1:0]    f_raddr;
   logic [BYTE_W-1:0]   raw_rd;
   logic [HEIGHT_W-1:0] f_rd;
   logic                f_we;
   logic [POS_W-1:0]    f_waddr;
   logic [HEIGHT_W-1:0] f_wdata;
   logic [HEIGHT_W-1:0] rsp_height;
   logic [POS_W-1:0]    rsp_row;
   logic [POS_W-1:0]    rsp_col;

   // configuration registers
   assign csr_pready = 1'b1;
   assign csr_idx    = csr_reg_type'(csr_paddr[CSR_ADDR_W-1:2]);
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      grid_width_in  = grid_width_ff;
      grid_depth_in  = grid_depth_ff;
      use_heights_in = use_heights_ff;
      if (csr_wr) begin
         case (csr_idx)
            REG_GRID_WIDTH:    grid_width_in  = csr_pwdata[DIM_W-1:0];
            REG_GRID_DEPTH:    grid_depth_in  = csr_pwdata[DIM_W-1:0];
            REG_USE_HEIGHTMAP: use_heights_in = csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         REG_GRID_WIDTH:    csr_prdata = CSR_DATA_W'(grid_width_ff);
         REG_GRID_DEPTH:    csr_prdata = CSR_DATA_W'(grid_depth_ff);
         REG_USE_HEIGHTMAP: csr_prdata = CSR_DATA_W'(use_heights_ff);
         default:           csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_width_ff  <= GRID_WIDTH_RST;
         grid_depth_ff  <= GRID_DEPTH_RST;
         use_heights_ff <= USE_HEIGHTS_RST;
      end else begin
         grid_width_ff  <= grid_width_in;
         grid_depth_ff  <= grid_depth_in;
         use_heights_ff <= use_heights_in;
      end
   end

   assign width_eff = clamp_dim(grid_width_ff, DIM_W'(MAX_WIDTH));
   assign depth_eff = clamp_dim(grid_depth_ff, DIM_W'(MAX_DEPTH));

   // item path; nothing is taken while reset is held
   assign req_tready = step_ready && !reset;
   assign req_accept = req_tvalid && req_tready;

   hbs_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .accept      (req_accept),
      .op          (req_tuser),
      .sample      (req_tdata[BYTE_W-1:0]),
      .width       (width_eff),
      .depth       (depth_eff),
      .step_active (step_active),
      .step        (step),
      .raw_we      (raw_we),
      .raw_waddr   (raw_waddr),
      .raw_raddr   (raw_raddr),
      .f_raddr     (f_raddr)
   );

   // raw bytes of the last row's worth of samples
   hbs_ram #(
      .DATA_W (BYTE_W),
      .DEPTH  (MAX_WIDTH)
   ) u_raw_line (
      .clock (clock),
      .we    (raw_we),
      .waddr (raw_waddr),
      .wdata (req_tdata[BYTE_W-1:0]),
      .re    (req_accept),
      .raddr (raw_raddr),
      .rdata (raw_rd)
   );

   // finished values of the row above the output point
   hbs_ram #(
      .DATA_W (HEIGHT_W),
      .DEPTH  (MAX_WIDTH)
   ) u_done_line (
      .clock (clock),
      .we    (f_we),
      .waddr (f_waddr),
      .wdata (f_wdata),
      .re    (req_accept),
      .raddr (f_raddr),
      .rdata (f_rd)
   );

   hbs_window u_window (
      .clock         (clock),
      .reset         (reset),
      .step_load     (req_accept && step_active),
      .step_in       (step),
      .raw_rd        (raw_rd),
      .f_rd          (f_rd),
      .use_heightmap (use_heights_ff),
      .rsp_ready     (rsp_tready),
      .step_ready    (step_ready),
      .f_we          (f_we),
      .f_waddr       (f_waddr),
      .f_wdata       (f_wdata),
      .rsp_valid     (rsp_tvalid),
      .rsp_height    (rsp_height),
      .rsp_row       (rsp_row),
      .rsp_col       (rsp_col),
      .rsp_last      (rsp_tlast)
   );

   assign rsp_tdata = {{RSP_PAD_W{1'b0}}, rsp_col, rsp_row, rsp_height};

endmodule
